// ===== hdl/spsi_pkg.sv =====
// ---------------------------------------------------------------------------
// spsi_pkg
// Shared types and constants for the signed permutation table block.
// ---------------------------------------------------------------------------
package spsi_pkg;

  // Field widths fixed by the interface
  localparam int ENTRY_W  = 5;   // one image point
  localparam int DEGREE_W = 6;   // degree register and image level
  localparam int LIMIT_W  = 11;  // table limit register and entry count

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = LIMIT_W;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'b1;

  // Register reset values
  localparam logic [DEGREE_W-1:0] DEGREE_RST = 6'd32;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 11'd1024;

  // Input word: one image point
  typedef struct packed {
    logic [ENTRY_W-1:0] image_entry;
    logic               negative_sign;
    logic               last_entry;
  } in_word_t;

  // Result word: one per completed image
  typedef struct packed {
    logic                status;
    logic                changed;
    logic [LIMIT_W-1:0]  entry_count;
    logic                neg_ident;
    logic [DEGREE_W-1:0] image_level;
  } out_word_t;

endpackage

// ===== hdl/spsi_row_match.sv =====
// ---------------------------------------------------------------------------
// spsi_row_match
// Compares one stored table row with the current image on the first
// degree points; points at or beyond the degree are ignored.
// ---------------------------------------------------------------------------
module spsi_row_match #(
  parameter int NUM_POINTS = 32,
  parameter int EW         = 5
) (
  input  logic [NUM_POINTS*EW-1:0]        row_img,
  input  logic [NUM_POINTS*EW-1:0]        ref_img,
  input  logic [spsi_pkg::DEGREE_W-1:0]   degree,
  output logic                            match
);
  import spsi_pkg::*;

  logic [NUM_POINTS-1:0] lane_ok;

  // Per-point compare, masked by the degree
  always_comb begin
    for (int i = 0; i < NUM_POINTS; i++) begin
      lane_ok[i] = (i >= int'(degree)) ||
                   (row_img[i*EW +: EW] == ref_img[i*EW +: EW]);
    end
  end

  assign match = &lane_ok;

endmodule

// ===== hdl/signed_permutation_strong_set_insert.sv =====
// ---------------------------------------------------------------------------
// signed_permutation_strong_set_insert
// Table of signed permutations with duplicate detection and a
// negative-identity flag.
// ---------------------------------------------------------------------------
// Usage:
//   An image is sent one point per word on in_word, from point zero up,
//   with start high; a word is taken when start is high and busy is low.
//   The word with last_entry set carries the sign and closes the image.
//   Non-final words are taken back to back, one per cycle.
//   After the final word busy rises; one result word appears on out_word
//   with out_valid high for exactly one cycle, and busy falls with it.
//   For the identity image the result is given from the prepare state;
//   otherwise the stored rows are searched first, up to the first hit, and
//   the table memory is scanned one row per cycle through its single read port.
//   The result is never held back: the receiver must take it when shown.
//   Configuration (cfg_we, cfg_index, cfg_data) is written while idle.
//   Reset empties the table, clears the flag and restores degree 32 and
//   limit 1024; no clearing pass is needed since rows are read only after
//   they are written.
// ---------------------------------------------------------------------------
module signed_permutation_strong_set_insert #(
  parameter int NUM_POINTS  = 32,
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  spsi_pkg::in_word_t                in_word,
  // result channel
  output logic                              out_valid,
  output spsi_pkg::out_word_t               out_word,
  // configuration
  input  logic                              cfg_we,
  input  logic [spsi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spsi_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import spsi_pkg::*;

  // Element width: identity fill values above 31 appear when NUM_POINTS exceeds 32
  localparam int EW     = (NUM_POINTS > 32) ? ENTRY_W + 1 : ENTRY_W;
  localparam int IMG_W  = NUM_POINTS * EW;
  localparam int ROW_W  = IMG_W + 1;
  localparam int IW     = $clog2(NUM_POINTS);
  localparam int LW     = $clog2(NUM_POINTS + 1);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_PREP   = 3'b010,
    ST_SEARCH = 3'b100
  } state_t;

  // Registers
  state_t               state_r, state_nxt;
  logic [DEGREE_W-1:0]  degree_r;
  logic [LIMIT_W-1:0]   limit_r;
  logic [LW-1:0]        load_idx_r, load_idx_nxt;
  logic                 moved_r, moved_nxt;
  logic [LW-1:0]        first_mv_r, first_mv_nxt;
  logic [ENTRY_W-1:0]   buf_r [NUM_POINTS];
  logic                 sign_r, sign_nxt;
  logic [DEGREE_W-1:0]  d_r, d_nxt;
  logic [DEGREE_W-1:0]  level_r, level_nxt;
  logic [LW-1:0]        img_len_r, img_len_nxt;
  logic [IMG_W-1:0]     img_r, img_nxt;
  logic [CNT_W-1:0]     scan_r, scan_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [ROW_W-1:0]     rd_row_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 flag_r, flag_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_word_t            out_word_r, out_word_nxt;

  // Table memory: {sign, image} per row
  logic [ROW_W-1:0]     tbl_mem [TABLE_DEPTH];

  // Combinational helpers
  logic                 in_accept;
  logic                 load_ok;
  logic                 entry_moved;
  logic                 mv_now;
  logic [LW-1:0]        fm_now;
  logic [LW-1:0]        len_now;
  logic [DEGREE_W-1:0]  d_eff;
  logic [DEGREE_W-1:0]  level_now;
  logic [31:0]          eff_lim;
  logic [IMG_W-1:0]     img_asm;
  logic                 row_hit;
  logic                 buf_we;
  logic                 mem_we;
  logic                 mem_re;
  logic                 res_status;
  logic                 res_changed;

  assign busy      = (state_r != ST_IDLE);
  assign in_accept = start && !busy;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Effective degree and limit
  always_comb begin
    priority if (degree_r == '0) begin
      d_eff = DEGREE_W'(1);
    end else if (32'(degree_r) > NUM_POINTS) begin
      d_eff = DEGREE_W'(NUM_POINTS);
    end else begin
      d_eff = degree_r;
    end
  end

  assign eff_lim = (32'(limit_r) > TABLE_DEPTH) ? 32'(TABLE_DEPTH) : 32'(limit_r);

  // Point loading and running first-moved-point search
  assign load_ok     = (32'(load_idx_r) < NUM_POINTS);
  assign entry_moved = load_ok && (32'(in_word.image_entry) != 32'(load_idx_r));
  assign mv_now      = moved_r || entry_moved;
  assign fm_now      = moved_r ? first_mv_r : load_idx_r;
  assign len_now     = load_ok ? load_idx_r + LW'(1) : load_idx_r;
  assign level_now   = (mv_now && (32'(fm_now) < 32'(d_eff))) ?
                       DEGREE_W'(fm_now) : d_eff;

  // Full image: points not received are fixed points
  always_comb begin
    for (int i = 0; i < NUM_POINTS; i++) begin
      img_asm[i*EW +: EW] = (i < int'(img_len_r)) ? EW'(buf_r[i]) : EW'(i);
    end
  end

  spsi_row_match #(
    .NUM_POINTS (NUM_POINTS),
    .EW         (EW)
  ) u_row_match (
    .row_img (rd_row_r[IMG_W-1:0]),
    .ref_img (img_r),
    .degree  (d_r),
    .match   (row_hit)
  );

  // Control
  always_comb begin
    state_nxt     = state_r;
    load_idx_nxt  = load_idx_r;
    moved_nxt     = moved_r;
    first_mv_nxt  = first_mv_r;
    sign_nxt      = sign_r;
    d_nxt         = d_r;
    level_nxt     = level_r;
    img_len_nxt   = img_len_r;
    img_nxt       = img_r;
    scan_nxt      = scan_r;
    rd_vld_nxt    = 1'b0;
    cnt_nxt       = cnt_r;
    flag_nxt      = flag_r;
    out_valid_nxt = 1'b0;
    buf_we        = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    res_status    = 1'b0;
    res_changed   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          buf_we       = load_ok;
          load_idx_nxt = len_now;
          moved_nxt    = mv_now;
          first_mv_nxt = fm_now;
          if (in_word.last_entry) begin
            sign_nxt     = in_word.negative_sign;
            d_nxt        = d_eff;
            level_nxt    = level_now;
            img_len_nxt  = len_now;
            load_idx_nxt = '0;
            moved_nxt    = 1'b0;
            first_mv_nxt = '0;
            state_nxt    = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        img_nxt  = img_asm;
        scan_nxt = '0;
        if (level_r == d_r) begin
          // identity image: only the sign matters
          if (sign_r && !flag_r) begin
            flag_nxt    = 1'b1;
            res_changed = 1'b1;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (rd_vld_r && row_hit) begin
          // duplicate found; opposite sign sets the flag
          if ((rd_row_r[ROW_W-1] != sign_r) && !flag_r) begin
            flag_nxt    = 1'b1;
            res_changed = 1'b1;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (!rd_vld_r && (scan_r == cnt_r)) begin
          // no match in any stored row
          if (32'(cnt_r) >= eff_lim) begin
            res_status = 1'b1;
          end else begin
            mem_we      = 1'b1;
            cnt_nxt     = cnt_r + CNT_W'(1);
            res_changed = 1'b1;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (scan_r != cnt_r) begin
          mem_re     = 1'b1;
          scan_nxt   = scan_r + CNT_W'(1);
          rd_vld_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_word_nxt = out_word_r;
    if (out_valid_nxt) begin
      out_word_nxt.status      = res_status;
      out_word_nxt.changed     = res_changed;
      out_word_nxt.entry_count = LIMIT_W'(cnt_nxt);
      out_word_nxt.neg_ident   = flag_nxt;
      out_word_nxt.image_level = level_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      degree_r    <= DEGREE_RST;
      limit_r     <= LIMIT_RST;
      load_idx_r  <= '0;
      moved_r     <= 1'b0;
      first_mv_r  <= '0;
      scan_r      <= '0;
      rd_vld_r    <= 1'b0;
      cnt_r       <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_idx_r  <= load_idx_nxt;
      moved_r     <= moved_nxt;
      first_mv_r  <= first_mv_nxt;
      scan_r      <= scan_nxt;
      rd_vld_r    <= rd_vld_nxt;
      cnt_r       <= cnt_nxt;
      flag_r      <= flag_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DEGREE: degree_r <= cfg_data[DEGREE_W-1:0];
          CFG_LIMIT:  limit_r  <= cfg_data;
          default:    ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sign_r     <= sign_nxt;
    d_r        <= d_nxt;
    level_r    <= level_nxt;
    img_len_r  <= img_len_nxt;
    img_r      <= img_nxt;
    out_word_r <= out_word_nxt;
    if (buf_we) begin
      buf_r[load_idx_r[IW-1:0]] <= in_word.image_entry;
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[cnt_r[AW-1:0]] <= {sign_r, img_r};
    end
    if (mem_re) begin
      rd_row_r <= tbl_mem[scan_r[AW-1:0]];
    end
  end

  // Assertions
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result shown while block busy");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= TABLE_DEPTH)
    else $error("entry count beyond table depth");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_SEARCH) |=> (cnt_r == $past(cnt_r)))
    else $error("entry count changed outside search");

  a_rd_search: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == ST_SEARCH))
    else $error("row read outstanding outside search");

endmodule

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for signed_permutation_strong_set_insert: drives
// images one word at a time with bursty timing, predicts the result of each
// closed image (append, duplicate, sign clash, identity or table full), and
// checks every result word against the oldest prediction.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import spsi_pkg::*;

  localparam int NUM_POINTS    = 32;
  localparam int TABLE_DEPTH   = 1024;
  localparam int ITEM_TARGET   = 1175;
  localparam int CYCLE_LIMIT   = 10_000_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_MAX    = 10;

  typedef logic [NUM_POINTS-1:0][ENTRY_W-1:0] image_t;

  // Table predictor and store of awaited result words
  class table_predictor_c;
    logic [DEGREE_W-1:0] degree_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    image_t              point_buf;
    int                  points_held;
    image_t              stored_rows[$];
    bit                  stored_signs[$];
    bit                  neg_flag;
    out_word_t           awaited[$];
    int                  bad_results;

    function new();
      degree_reg  = DEGREE_RST;
      limit_reg   = LIMIT_RST;
      point_buf   = '0;
      points_held = 0;
      neg_flag    = 1'b0;
      bad_results = 0;
    endfunction

    function int eff_degree();
      if (degree_reg == 0) return 1;
      if (degree_reg > NUM_POINTS) return NUM_POINTS;
      return int'(degree_reg);
    endfunction

    function int eff_limit();
      if (limit_reg > TABLE_DEPTH) return TABLE_DEPTH;
      return int'(limit_reg);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_DEGREE) begin
        degree_reg = data[DEGREE_W-1:0];
      end else if (idx == CFG_LIMIT) begin
        limit_reg = data[LIMIT_W-1:0];
      end
    endfunction

    // only the first d points take part in the comparison
    function bit rows_match(image_t a, image_t b, int d);
      for (int j = 0; j < d; j++) begin
        if (a[j] != b[j]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // note one accepted word; a closing word yields one awaited result
    function void take_word(in_word_t w);
      image_t    img;
      int        d;
      int        level;
      int        hit;
      out_word_t exp_w;
      if (points_held < NUM_POINTS) begin
        point_buf[points_held] = w.image_entry;
        points_held++;
      end
      if (!w.last_entry) return;
      d = eff_degree();
      // points never received are fixed points
      for (int i = 0; i < NUM_POINTS; i++) begin
        img[i] = (i < points_held) ? point_buf[i] : ENTRY_W'(i);
      end
      points_held = 0;
      level = d;
      for (int i = d - 1; i >= 0; i--) begin
        if (img[i] != ENTRY_W'(i)) level = i;
      end
      exp_w = '0;
      if (level == d) begin
        // identity: a negative sign raises the flag
        if (w.negative_sign && !neg_flag) begin
          neg_flag = 1'b1;
          exp_w.changed = 1'b1;
        end
      end else begin
        hit = -1;
        foreach (stored_rows[r]) begin
          if (hit < 0 && rows_match(stored_rows[r], img, d)) hit = r;
        end
        if (hit >= 0) begin
          // same image, other sign: the flag goes up
          if (stored_signs[hit] != w.negative_sign && !neg_flag) begin
            neg_flag = 1'b1;
            exp_w.changed = 1'b1;
          end
        end else if (stored_rows.size() >= eff_limit()) begin
          exp_w.status = 1'b1;
        end else begin
          stored_rows.push_back(img);
          stored_signs.push_back(w.negative_sign);
          exp_w.changed = 1'b1;
        end
      end
      exp_w.entry_count = LIMIT_W'(stored_rows.size());
      exp_w.neg_ident   = neg_flag;
      exp_w.image_level = DEGREE_W'(level);
      awaited.push_back(exp_w);
    endfunction

    function void check_result(out_word_t got);
      out_word_t exp_w;
      if (awaited.size() == 0) begin
        bad_results++;
        if (bad_results <= REPORT_MAX) begin
          $display("error at %0t: result word with none awaited:", $time);
          $display("              got st=%0d ch=%0d cnt=%0d neg=%0d lvl=%0d",
                   got.status, got.changed, got.entry_count,
                   got.neg_ident, got.image_level);
        end
        return;
      end
      exp_w = awaited.pop_front();
      if (got.status !== exp_w.status || got.changed !== exp_w.changed ||
          got.entry_count !== exp_w.entry_count ||
          got.neg_ident !== exp_w.neg_ident ||
          got.image_level !== exp_w.image_level) begin
        bad_results++;
        if (bad_results <= REPORT_MAX) begin
          $display("error at %0t: exp st=%0d ch=%0d cnt=%0d neg=%0d lvl=%0d", $time,
                   exp_w.status, exp_w.changed, exp_w.entry_count,
                   exp_w.neg_ident, exp_w.image_level);
          $display("              got st=%0d ch=%0d cnt=%0d neg=%0d lvl=%0d",
                   got.status, got.changed, got.entry_count,
                   got.neg_ident, got.image_level);
        end
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_word_t              in_word   = '0;
  logic                  out_valid;
  out_word_t             out_word;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  table_predictor_c      table_predictor = new();
  logic [ENTRY_W-1:0]    image_q[$];
  int                    items_sent  = 0;
  int                    burst_left  = 0;
  bit                    no_gaps     = 1'b0;
  int                    cycle_count = 0;

  signed_permutation_strong_set_insert #(
    .NUM_POINTS (NUM_POINTS),
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result monitor: a strobed word is taken at the edge ending its cycle
  always @(posedge clk) begin
    if (rst_n && out_valid) table_predictor.check_result(out_word);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one word, sent in bursts with random gaps between them
  task automatic send_word(in_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    table_predictor.take_word(w);
    items_sent++;
  endtask

  // send image_q; the last word closes the image only when asked
  task automatic send_image(bit sign, bit close = 1'b1);
    in_word_t w;
    foreach (image_q[k]) begin
      w.image_entry   = image_q[k];
      w.last_entry    = close && (k == image_q.size() - 1);
      w.negative_sign = w.last_entry ? sign : 1'($urandom_range(0, 1));
      send_word(w);
    end
  endtask

  // hold off until every awaited result has come, then let the block settle
  task automatic drain();
    start <= 1'b0;
    while (table_predictor.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(logic [CFG_DATA_W-1:0] degree_data,
                          logic [CFG_DATA_W-1:0] limit_data);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEGREE;
    cfg_data  <= degree_data;
    @(posedge clk);
    table_predictor.write_reg(CFG_DEGREE, degree_data);
    cfg_index <= CFG_LIMIT;
    cfg_data  <= limit_data;
    @(posedge clk);
    table_predictor.write_reg(CFG_LIMIT, limit_data);
    cfg_we <= 1'b0;
  endtask

  task automatic make_identity(int d);
    image_q.delete();
    for (int i = 0; i < d; i++) image_q.push_back(ENTRY_W'(i));
  endtask

  // shuffled identity of d points
  task automatic make_perm(int d);
    int                 j;
    logic [ENTRY_W-1:0] t;
    make_identity(d);
    for (int i = d - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = image_q[i];
      image_q[i] = image_q[j];
      image_q[j] = t;
    end
  endtask

  // mostly clean permutations and repeats, plus identity, short, long and junk images
  task automatic send_random_image();
    int d;
    int kind;
    int n;
    int r;
    bit sign;
    d    = table_predictor.eff_degree();
    kind = $urandom_range(0, 99);
    sign = 1'($urandom_range(0, 1));
    if (kind < 55) begin
      make_perm(d);
    end else if (kind < 70 && table_predictor.stored_rows.size() > 0) begin
      r = $urandom_range(0, table_predictor.stored_rows.size() - 1);
      image_q.delete();
      for (int j = 0; j < d; j++) image_q.push_back(table_predictor.stored_rows[r][j]);
    end else if (kind < 78) begin
      make_identity(d);
    end else if (kind < 86) begin
      make_perm(d);
      n = $urandom_range(1, d);
      while (image_q.size() > n) void'(image_q.pop_back());
    end else if (kind < 92) begin
      make_perm(d);
      n = $urandom_range(d + 1, NUM_POINTS + 4);
      while (image_q.size() < n) image_q.push_back(ENTRY_W'($urandom_range(0, 31)));
    end else begin
      image_q.delete();
      repeat (d) image_q.push_back(ENTRY_W'($urandom_range(0, 31)));
    end
    send_image(sign);
    if ($urandom_range(0, 29) == 0) drain();
  endtask

  // stimulus
  initial begin
    logic [DEGREE_W-1:0] deg;
    logic [LIMIT_W-1:0]  lim;
    int                  n_img;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: degree 3, roomy table
    set_regs(CFG_DATA_W'(3), LIMIT_RST);
    make_identity(3);
    send_image(1'b0);
    image_q = '{1, 0, 2};
    send_image(1'b0);
    image_q = '{0, 2, 1};
    send_image(1'b1);
    // the flag can go up only once; pick which path raises it
    if ($urandom_range(0, 1) == 1) begin
      image_q = '{1, 0, 2};
      send_image(1'b1);
      make_identity(3);
      send_image(1'b1);
    end else begin
      make_identity(3);
      send_image(1'b1);
      image_q = '{1, 0, 2};
      send_image(1'b1);
    end
    // repeat with the same sign
    image_q = '{1, 0, 2};
    send_image(1'b0);
    // short image, rest fixed
    image_q = '{2};
    send_image(1'b0);
    // degree changed while an image is half loaded
    image_q = '{2, 0};
    send_image(1'b0, 1'b0);
    drain();
    set_regs(CFG_DATA_W'(2), LIMIT_RST);
    image_q = '{1};
    send_image(1'b1);
    // no room at all
    drain();
    set_regs(CFG_DATA_W'(2), '0);
    image_q = '{31, 30};
    send_image(1'b0);
    // degree 0 acts as 1, limit above depth acts as depth
    drain();
    set_regs({5'h1f, 6'd0}, 11'd2047);
    image_q = '{0};
    send_image(1'b1);
    image_q = '{5};
    send_image(1'b0);

    // random phases, each with its own register setting
    while (items_sent < ITEM_TARGET) begin
      drain();
      case ($urandom_range(0, 7))
        0:       deg = 6'd0;
        1:       deg = 6'd1;
        2:       deg = 6'd32;
        3:       deg = DEGREE_W'($urandom_range(33, 63));
        default: deg = DEGREE_W'($urandom_range(2, 6));
      endcase
      case ($urandom_range(0, 5))
        0:       lim = '0;
        1:       lim = 11'd1;
        2:       lim = 11'd1024;
        3:       lim = LIMIT_W'($urandom_range(1025, 2047));
        default: lim = LIMIT_W'(table_predictor.stored_rows.size() + $urandom_range(0, 6));
      endcase
      set_regs({5'($urandom_range(0, 31)), deg}, lim);
      no_gaps = ($urandom_range(0, 3) == 0);
      n_img = (table_predictor.eff_degree() >= 16) ? $urandom_range(2, 6)
                                                   : $urandom_range(4, 20);
      repeat (n_img) begin
        if (items_sent < ITEM_TARGET) send_random_image();
      end
    end

    drain();
    repeat (table_predictor.stored_rows.size() + 16) @(posedge clk);
    if (table_predictor.bad_results == 0 && table_predictor.awaited.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
